### rtl/uhnr_pkg.sv
// Package for the unit hydrograph nutrient router: opcodes, register indexes,
// FSM states and the control structs passed between the router modules.
// No dependencies.
package uhnr_pkg;

    localparam int KINDS = 10;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic CFG_AREA  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [3:0] KIND_FIRST_UNSCALED = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_RD,
        ST_SUM,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        start;
        logic [9:0]  cell_idx;
        logic [3:0]  kind;
        logic [31:0] amount;
        logic [31:0] area;
        logic [16:0] frac;
    } t_line_ctrl;

    typedef struct packed {
        logic        we;
        logic [9:0]  cell_idx;
        logic [4:0]  slot;
        logic [15:0] data;
    } t_wt_wr;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [39:0] arrival;
    } t_line_stat;

endpackage

### rtl/uhnr_div.sv
// Fraction unit: clamped Q1.16 fraction num/den by restoring division,
// one quotient bit per cycle. Depends on uhnr_pkg.
module uhnr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [16:0] o_frac
);
    import uhnr_pkg::*;

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_q;
    logic        r_special;
    logic [16:0] r_spec_val;
    logic        r_done;
    logic [16:0] r_frac;

    logic [32:0] rem2;
    logic        ge;
    logic [31:0] n_rem;
    logic [32:0] diff;

    always_comb begin
        rem2  = {r_rem, 1'b0};
        diff  = rem2 - {1'b0, r_den};
        ge    = (rem2 >= {1'b0, r_den});
        n_rem = ge ? diff[31:0] : rem2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem      <= i_num;
            r_den      <= i_den;
            r_special  <= (i_den == 32'd0) || (i_num >= i_den);
            r_spec_val <= (i_num == 32'd0) ? 17'd0 : ONE_Q16;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[14:0], ge};
            if (r_cnt == 4'd15) begin
                r_frac <= r_special ? r_spec_val : {1'b0, r_q[14:0], ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_frac = r_frac;

endmodule

### rtl/uhnr_line.sv
// Delay line and weight memories with the slot walk pipeline: read, scale by
// weight, area and fraction, saturating add, write back. Depends on uhnr_pkg.
module uhnr_line #(
    parameter int CELLS = 1024,
    parameter int SLOTS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  uhnr_pkg::t_line_ctrl i_ctrl,
    input  uhnr_pkg::t_wt_wr     i_wt,
    output uhnr_pkg::t_line_stat o_stat
);
    import uhnr_pkg::*;

    localparam int DEPTH  = CELLS * KINDS * SLOTS;
    localparam int LAW    = $clog2(DEPTH);
    localparam int WDEPTH = CELLS * SLOTS;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int SW     = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    logic [39:0] r_dly_mem [DEPTH];
    logic [15:0] r_w_mem   [WDEPTH];
    logic [39:0] r_dly_rd;
    logic [15:0] r_w_rd;

    logic           r_clr_busy;
    logic [LAW-1:0] r_clr_addr;

    logic           r_iss;
    logic [SW-1:0]  r_j;
    logic [LAW-1:0] r_base;
    logic [WAW-1:0] r_wbase;
    logic [31:0]    r_amount;
    logic [31:0]    r_area;
    logic [16:0]    r_frac;

    logic          r_v1, r_v2, r_v3, r_v4;
    logic [SW-1:0] r_j1, r_j2, r_j3, r_j4;
    logic          r_z1;
    logic [39:0]   r_old2, r_old3, r_old4;
    logic [31:0]   r_a;
    logic [47:0]   r_b;
    logic [39:0]   r_c;
    logic          r_done;
    logic [39:0]   r_arrival;

    logic [LAW-1:0] dly_rd_addr;
    logic [WAW-1:0] w_rd_addr;
    logic [39:0]    old1;
    logic [47:0]    prod_a;
    logic [63:0]    prod_b;
    logic [64:0]    prod_c;
    logic [48:0]    c_wide;
    logic [39:0]    c_sat;
    logic [40:0]    sum4;
    logic [39:0]    sum_sat;
    logic           dly_we;
    logic [LAW-1:0] dly_wa;
    logic [39:0]    dly_wd;
    logic           w_we;
    logic [WAW-1:0] w_wa;
    logic [15:0]    w_wd;

    always_comb begin
        dly_rd_addr = (r_j == LAST) ? r_base : r_base + LAW'(r_j) + LAW'(1);
        w_rd_addr   = r_wbase + WAW'(r_j);
        old1        = r_z1 ? 40'd0 : r_dly_rd;
        prod_a      = r_amount * r_w_rd;
        prod_b      = r_a * r_area;
        prod_c      = r_b * r_frac;
        c_wide      = prod_c[64:16];
        c_sat       = (|c_wide[48:40]) ? MAX40 : c_wide[39:0];
        sum4        = {1'b0, r_old4} + {1'b0, r_c};
        sum_sat     = sum4[40] ? MAX40 : sum4[39:0];
    end

    // The clearing sweep owns both write ports until it has covered the line memory.
    always_comb begin
        dly_we = 1'b0;
        dly_wa = r_base + LAW'(r_j4);
        dly_wd = sum_sat;
        w_we   = 1'b0;
        w_wa   = WAW'(WAW'(i_wt.cell_idx) * WAW'(SLOTS) + WAW'(i_wt.slot));
        w_wd   = i_wt.data;
        if (r_clr_busy) begin
            dly_we = 1'b1;
            dly_wa = r_clr_addr;
            dly_wd = 40'd0;
            w_we   = (int'(r_clr_addr) < WDEPTH);
            w_wa   = WAW'(r_clr_addr);
            w_wd   = 16'd0;
        end else begin
            dly_we = r_v4;
            w_we   = i_wt.we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dly_we) begin
            r_dly_mem[dly_wa] <= dly_wd;
        end
        r_dly_rd <= r_dly_mem[dly_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_w_mem[w_wa] <= w_wd;
        end
        r_w_rd <= r_w_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_iss      <= 1'b0;
            r_j        <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + LAW'(1);
                if (r_clr_addr == LAW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_ctrl.start) begin
                r_iss <= 1'b1;
                r_j   <= '0;
            end else if (r_iss) begin
                if (r_j == LAST) begin
                    r_iss <= 1'b0;
                end else begin
                    r_j <= r_j + SW'(1);
                end
            end
            r_v1   <= r_iss;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_done <= r_v4 && (r_j4 == LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_base   <= LAW'((LAW'(i_ctrl.cell_idx) * LAW'(KINDS) + LAW'(i_ctrl.kind))
                             * LAW'(SLOTS));
            r_wbase  <= WAW'(WAW'(i_ctrl.cell_idx) * WAW'(SLOTS));
            r_amount <= i_ctrl.amount;
            r_area   <= i_ctrl.area;
            r_frac   <= i_ctrl.frac;
        end
        r_j1   <= r_j;
        r_z1   <= (r_j == LAST);
        r_j2   <= r_j1;
        r_old2 <= old1;
        r_a    <= prod_a[47:16];
        r_j3   <= r_j2;
        r_old3 <= r_old2;
        r_b    <= prod_b[63:16];
        r_j4   <= r_j3;
        r_old4 <= r_old3;
        r_c    <= c_sat;
        if (r_v4 && (r_j4 == '0)) begin
            r_arrival <= sum_sat;
        end
    end

    assign o_stat.busy    = r_clr_busy;
    assign o_stat.done    = r_done;
    assign o_stat.arrival = r_arrival;

endmodule

### rtl/uhnr_sums.sv
// Subbasin totals memory, one entry per subbasin and nutrient kind, with a
// clearing sweep after reset and on request. Depends on uhnr_pkg.
module uhnr_sums #(
    parameter int MAX_SUBBASINS = 64,
    localparam int SD = (MAX_SUBBASINS + 1) * uhnr_pkg::KINDS,
    localparam int AW = $clog2(SD)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [47:0]   i_wr_data,
    output logic [47:0]   o_rd_data,
    output logic          o_busy
);
    import uhnr_pkg::*;

    logic [47:0]   r_mem [SD];
    logic [47:0]   r_rd;
    logic          r_busy;
    logic [AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_addr] <= 48'd0;
        end else if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (i_clr) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            r_addr <= r_addr + AW'(1);
            if (r_addr == AW'(SD - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_busy;

endmodule

### rtl/unit_hydrograph_nutrient_router_core.sv
// Unit hydrograph nutrient router top level: stream ports, configuration,
// control FSM and watershed totals. Depends on uhnr_pkg, uhnr_div, uhnr_line, uhnr_sums.
//
// One transaction in gives one result transaction out, in order. A cell step runs
// through the bit-serial fraction divider, then one slot per cycle through the read
// and write ports of the delay line memory, a multiply pipeline and a read-modify-write
// of the subbasin totals memory. A clear of the totals sweeps the totals memory
// before the next item is taken. After reset the delay line memory is swept to zero
// while no item is accepted; configuration writes are taken at any time. A new item
// is taken while a finished result waits at the output.
module unit_hydrograph_nutrient_router_core #(
    parameter int CELLS         = 1024,
    parameter int SLOTS         = 32,
    parameter int MAX_SUBBASINS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // cell_index, nutrient_kind, slot_index, weight_value, load_amount,
    // fraction_numerator, fraction_denominator, subbasin_id, zero pad
    input  logic [143:0] i_s_tdata,
    // opcode
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // arrival_amount, subbasin_total, watershed_total
    output logic [135:0] o_m_tdata,
    // bad_subbasin
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import uhnr_pkg::*;

    localparam int SD = (MAX_SUBBASINS + 1) * KINDS;
    localparam int AW = $clog2(SD);
    localparam int CW = $clog2(MAX_SUBBASINS + 1);

    logic [9:0]  in_cell;
    logic [3:0]  in_kind;
    logic [4:0]  in_slot;
    logic [15:0] in_weight;
    logic [31:0] in_amount;
    logic [31:0] in_num;
    logic [31:0] in_den;
    logic [6:0]  in_sid;

    assign in_cell   = i_s_tdata[9:0];
    assign in_kind   = i_s_tdata[13:10];
    assign in_slot   = i_s_tdata[18:14];
    assign in_weight = i_s_tdata[34:19];
    assign in_amount = i_s_tdata[66:35];
    assign in_num    = i_s_tdata[98:67];
    assign in_den    = i_s_tdata[130:99];
    assign in_sid    = i_s_tdata[137:131];

    t_state r_state, n_state;

    logic [1:0]  r_op;
    logic [9:0]  r_cell;
    logic [3:0]  r_kind;
    logic [31:0] r_amount;
    logic [6:0]  r_sid;
    logic [31:0] r_area;
    logic [6:0]  r_count;
    logic [47:0] r_ws [KINDS];

    logic [39:0] r_res_arr;
    logic [47:0] r_res_sub;
    logic [47:0] r_res_ws;
    logic        r_res_bad;

    logic         r_out_valid;
    logic [135:0] r_out_data;
    logic         r_out_bad;

    logic s_acc;
    logic step_ok;
    logic query_ok;
    logic div_start;
    logic line_start;
    logic sum_rd;
    logic sum_we;
    logic sum_clr;
    logic out_load;

    logic        div_done;
    logic [16:0] div_frac;
    logic [16:0] frac_sel;

    t_line_ctrl lctrl;
    t_wt_wr     wt;
    t_line_stat lstat;

    logic [47:0]   sum_rd_data;
    logic          sum_busy;
    logic [CW-1:0] eff;
    logic          sb_one;
    logic          bad;
    logic [AW-1:0] sum_addr;
    logic [48:0]   sub_add;
    logic [47:0]   sub_new;
    logic [48:0]   ws_add;
    logic [47:0]   ws_new;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign step_ok  = (int'(in_cell) < CELLS) && (int'(in_kind) < KINDS);
    assign query_ok = (int'(in_kind) < KINDS);

    // Subbasin resolution: a single subbasin in use takes every id.
    always_comb begin
        if (r_count == 7'd0) begin
            eff = CW'(1);
        end else if (int'(r_count) > MAX_SUBBASINS) begin
            eff = CW'(MAX_SUBBASINS);
        end else begin
            eff = CW'(r_count);
        end
        sb_one   = (eff == CW'(1));
        bad      = !sb_one && ((r_sid == 7'd0) || (int'(r_sid) > int'(eff)));
        sum_addr = (sb_one || bad) ? AW'(KINDS + int'(r_kind))
                                   : AW'(int'(r_sid) * KINDS + int'(r_kind));
        sub_add  = {1'b0, sum_rd_data} + {9'd0, r_res_arr};
        sub_new  = sub_add[48] ? MAX48 : sub_add[47:0];
        ws_add   = {1'b0, r_ws[r_kind]} + {9'd0, r_res_arr};
        ws_new   = ws_add[48] ? MAX48 : ws_add[47:0];
        frac_sel = (r_kind >= KIND_FIRST_UNSCALED) ? ONE_Q16 : div_frac;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == OP_STEP && step_ok) begin
                        n_state = ST_DIV;
                    end else if (i_s_tuser == OP_QUERY && query_ok) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DIV:  if (div_done) n_state = ST_WALK;
            ST_WALK: if (lstat.done) n_state = ST_RD;
            ST_RD:   n_state = ST_SUM;
            ST_SUM:  n_state = ST_FIN;
            ST_FIN:  if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == ST_IDLE) && !lstat.busy && !sum_busy;
        div_start  = s_acc && (i_s_tuser == OP_STEP) && step_ok;
        line_start = (r_state == ST_DIV) && div_done;
        sum_rd     = (r_state == ST_RD);
        sum_we     = (r_state == ST_SUM) && (r_op == OP_STEP) && !bad;
        sum_clr    = s_acc && (i_s_tuser == OP_CLEAR);
        out_load   = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);
    end

    always_comb begin
        lctrl.start    = line_start;
        lctrl.cell_idx = r_cell;
        lctrl.kind     = r_kind;
        lctrl.amount   = r_amount;
        lctrl.area     = r_area;
        lctrl.frac     = frac_sel;
        wt.we       = s_acc && (i_s_tuser == OP_LOAD) && (int'(in_cell) < CELLS)
                      && (int'(in_slot) < SLOTS);
        wt.cell_idx = in_cell;
        wt.slot     = in_slot;
        wt.data     = in_weight;
    end

    uhnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (in_num),
        .i_den   (in_den),
        .o_done  (div_done),
        .o_frac  (div_frac)
    );

    uhnr_line #(
        .CELLS (CELLS),
        .SLOTS (SLOTS)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lctrl),
        .i_wt    (wt),
        .o_stat  (lstat)
    );

    uhnr_sums #(
        .MAX_SUBBASINS (MAX_SUBBASINS)
    ) u_sums (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (sum_clr),
        .i_rd_en   (sum_rd),
        .i_rd_addr (sum_addr),
        .i_we      (sum_we),
        .i_wr_addr (sum_addr),
        .i_wr_data (sub_new),
        .o_rd_data (sum_rd_data),
        .o_busy    (sum_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_area      <= 32'd65536;
            r_count     <= 7'd1;
            r_out_valid <= 1'b0;
            for (int k = 0; k < KINDS; k++) begin
                r_ws[k] <= 48'd0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_AREA:  r_area  <= i_cfg_data;
                    CFG_COUNT: r_count <= i_cfg_data[6:0];
                    default:   r_area  <= r_area;
                endcase
            end
            if (sum_clr) begin
                for (int k = 0; k < KINDS; k++) begin
                    r_ws[k] <= 48'd0;
                end
            end else if (sum_we) begin
                r_ws[r_kind] <= ws_new;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op      <= i_s_tuser;
            r_cell    <= in_cell;
            r_kind    <= in_kind;
            r_amount  <= in_amount;
            r_sid     <= in_sid;
            r_res_arr <= 40'd0;
            r_res_sub <= 48'd0;
            r_res_ws  <= 48'd0;
            r_res_bad <= 1'b0;
        end
        if (r_state == ST_WALK && lstat.done) begin
            r_res_arr <= lstat.arrival;
        end
        if (r_state == ST_SUM) begin
            r_res_bad <= bad;
            if (r_op == OP_STEP) begin
                r_res_sub <= bad ? 48'd0 : sub_new;
                r_res_ws  <= bad ? r_ws[r_kind] : ws_new;
            end else begin
                r_res_sub <= bad ? 48'd0 : sum_rd_data;
                r_res_ws  <= r_ws[r_kind];
            end
        end
        if (out_load) begin
            r_out_data <= {r_res_ws, r_res_sub, r_res_arr};
            r_out_bad  <= r_res_bad;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_bad;
    assign o_cfg_ready = 1'b1;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("input accepted on two consecutive cycles");

    a_line_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_start |-> !lstat.busy)
        else $error("slot walk started during the clearing sweep");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_m_tvalid)
        else $error("finished result did not reach the output register");

endmodule

### dv/tb.sv
// Self-checking testbench for unit_hydrograph_nutrient_router_core.
// It holds its own routing predictor and checks each result against it or, for typed
// directed rows, against the given result. It needs only uhnr_pkg and the router RTL.
module tb;
    import uhnr_pkg::*;

    localparam int NSLOTS    = 32;
    localparam int NSUB      = 64;
    localparam int LIMIT     = 3_000_000;
    localparam int HOLD_LEN  = 3000;
    localparam int N_RANDOM  = 1000;
    localparam int SETTLE    = 800;

    typedef struct {
        logic [1:0]  op;
        logic [9:0]  cell_idx;
        logic [3:0]  kind;
        logic [4:0]  slot;
        logic [15:0] weight;
        logic [31:0] amount;
        logic [31:0] num;
        logic [31:0] den;
        logic [6:0]  sid;
    } t_item;

    typedef struct {
        logic [39:0] arrival;
        logic [47:0] sub_total;
        logic [47:0] ws_total;
        logic        bad;
    } t_route;

    typedef struct {
        t_item  item;
        logic   typed;
        t_route want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [135:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [0:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    unit_hydrograph_nutrient_router_core u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state.
    logic [39:0] line_mem [int];
    logic [15:0] weight_mem [int];
    logic [47:0] sub_sums [0:NSUB][0:KINDS-1];
    logic [47:0] ws_sums [0:KINDS-1];
    logic [31:0] area_reg;
    logic [6:0]  count_reg;

    t_route expected_routes [$];
    int errors = 0;
    int cycles = 0;
    int n_sent = 0;
    bit quiet = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
    endtask

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

    function automatic logic [16:0] fraction_q16(input logic [31:0] num, input logic [31:0] den);
        logic [47:0] q;
        if (den == 0) return (num != 0) ? ONE_Q16 : 17'd0;
        if (num >= den) return ONE_Q16;
        q = {num, 16'd0} / den;
        return q[16:0];
    endfunction

    // Returns the subbasin index, or -1 for an invalid id.
    function automatic int subbasin_of(input logic [6:0] sid);
        int c;
        c = int'(count_reg);
        if (c == 0) c = 1;
        if (c > NSUB) c = NSUB;
        if (c == 1) return 1;
        if (sid == 0 || int'(sid) > c) return -1;
        return int'(sid);
    endfunction

    function automatic t_route route_item(input t_item it);
        t_route r;
        int base, wbase, sb;
        logic [39:0] cur [NSLOTS];
        logic [16:0] frac;
        logic [47:0] a;
        logic [95:0] b, c;
        logic [40:0] s;
        r = '{default: '0};
        case (it.op)
            OP_LOAD: weight_mem[it.cell_idx * NSLOTS + it.slot] = it.weight;
            OP_CLEAR: begin
                foreach (sub_sums[i, k]) sub_sums[i][k] = '0;
                foreach (ws_sums[k]) ws_sums[k] = '0;
            end
            OP_STEP: if (it.kind < KINDS) begin
                base = (it.cell_idx * KINDS + it.kind) * NSLOTS;
                wbase = it.cell_idx * NSLOTS;
                for (int j = 0; j < NSLOTS; j++) begin
                    if (j == NSLOTS - 1) cur[j] = '0;
                    else cur[j] = line_mem.exists(base + j + 1) ? line_mem[base + j + 1] : '0;
                end
                frac = (it.kind >= KIND_FIRST_UNSCALED) ? ONE_Q16 : fraction_q16(it.num, it.den);
                if (it.amount != 0) begin
                    for (int j = 0; j < NSLOTS; j++) begin
                        a = (48'(it.amount) * (weight_mem.exists(wbase + j) ?
                             weight_mem[wbase + j] : 16'd0)) >> 16;
                        b = (96'(a) * area_reg) >> 16;
                        c = (b * frac) >> 16;
                        if (c > MAX40) c = MAX40;
                        s = {1'b0, cur[j]} + {1'b0, c[39:0]};
                        cur[j] = s[40] ? MAX40 : s[39:0];
                    end
                end
                for (int j = 0; j < NSLOTS; j++) line_mem[base + j] = cur[j];
                r.arrival = cur[0];
                sb = subbasin_of(it.sid);
                if (sb < 0) r.bad = 1'b1;
                else begin
                    sub_sums[sb][it.kind] = sat48(sub_sums[sb][it.kind], cur[0]);
                    r.sub_total = sub_sums[sb][it.kind];
                    ws_sums[it.kind] = sat48(ws_sums[it.kind], cur[0]);
                end
                r.ws_total = ws_sums[it.kind];
            end
            OP_QUERY: if (it.kind < KINDS) begin
                sb = subbasin_of(it.sid);
                if (sb < 0) r.bad = 1'b1;
                else r.sub_total = sub_sums[sb][it.kind];
                r.ws_total = ws_sums[it.kind];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_AREA) area_reg = value;
        else count_reg = value[6:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Offers one item; the valid stays high into the next item unless a gap follows.
    task automatic send_item(input t_item it, input logic typed, input t_route want);
        t_route r;
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(7) == 0) begin
            i_s_tvalid = 1'b0;
            gap = $urandom_range(15, 1);
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = it.op;
        i_s_tdata = {6'd0, it.sid, it.den, it.num, it.amount, it.weight,
                     it.slot, it.kind, it.cell_idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = route_item(it);
        expected_routes.push_back(typed ? want : r);
        n_sent++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        wait (expected_routes.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32'h3_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int p;
        p = $urandom_range(99);
        it.op = (p < 30) ? OP_LOAD : (p < 85) ? OP_STEP : (p < 98) ? OP_QUERY : OP_CLEAR;
        case ($urandom_range(9))
            0: it.cell_idx = 10'($urandom);
            1: it.cell_idx = 10'h3FF;
            default: it.cell_idx = 10'($urandom_range(3));
        endcase
        it.kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
        it.slot = 5'($urandom);
        it.weight = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom);
        it.amount = pick32();
        it.num = pick32();
        it.den = pick32();
        it.sid = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(8));
        return it;
    endfunction

    // Result side: random stalls, one long hold-off, and an always-ready tail.
    initial begin
        int stall_left, hold_left;
        bit held;
        stall_left = 0;
        hold_left = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= 300) begin
                held = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else if (quiet) begin
                i_m_tready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready = 1'b0;
            end else if ($urandom_range(5) == 0) begin
                stall_left = $urandom_range(15, 1) - 1;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_route want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_routes.size() == 0) begin
                report("unexpected result", o_m_tdata[47:0], 48'd0);
            end else begin
                want = expected_routes.pop_front();
                if (o_m_tdata[39:0] !== want.arrival)
                    report("arrival_amount", o_m_tdata[39:0], want.arrival);
                if (o_m_tdata[87:40] !== want.sub_total)
                    report("subbasin_total", o_m_tdata[87:40], want.sub_total);
                if (o_m_tdata[135:88] !== want.ws_total)
                    report("watershed_total", o_m_tdata[135:88], want.ws_total);
                if (o_m_tuser[0] !== want.bad)
                    report("bad_subbasin", o_m_tuser[0], want.bad);
            end
        end
    end

    initial begin
        t_row rows [$];
        t_route zero;
        logic [31:0] areas [5];
        logic [6:0]  counts [5];
        zero = '{default: '0};
        area_reg = 32'd65536;
        count_reg = 7'd1;
        foreach (sub_sums[i, k]) sub_sums[i][k] = '0;
        foreach (ws_sums[k]) ws_sums[k] = '0;

        // Directed rows: op, cell, kind, slot, weight, amount, num, den, sid.
        rows.push_back('{'{OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1}, 1, zero});
        rows.push_back('{'{OP_STEP, 5, 15, 0, 0, 32'hFFFF_FFFF, 1, 1, 1}, 1, zero});
        rows.push_back('{'{OP_LOAD, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0}, 1, zero});
        rows.push_back('{'{OP_LOAD, 0, 0, 1, 16'h8000, 0, 0, 0, 0}, 1, zero});
        rows.push_back('{'{OP_LOAD, 10'h3FF, 0, 31, 16'hFFFF, 0, 0, 0, 0}, 1, zero});
        rows.push_back('{'{OP_LOAD, 10'h3FF, 0, 0, 16'h0001, 0, 0, 0, 0}, 1, zero});
        // Zero denominator with zero numerator gives no load.
        rows.push_back('{'{OP_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1}, 0, zero});
        // Zero denominator with a positive numerator gives a full fraction.
        rows.push_back('{'{OP_STEP, 0, 1, 0, 0, 32'h1_0000, 5, 0, 1}, 0, zero});
        rows.push_back('{'{OP_STEP, 0, 3, 0, 0, 32'h7_0000, 1, 3, 127}, 0, zero});
        rows.push_back('{'{OP_STEP, 0, 6, 0, 0, 32'h7_0000, 9, 3, 0}, 0, zero});
        rows.push_back('{'{OP_STEP, 0, 7, 0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 64}, 0, zero});
        for (int i = 0; i < 4; i++)
            rows.push_back('{'{OP_STEP, 10'h3FF, 9, 0, 0, 32'hFFFF_FFFF, 0, 0, 1}, 0, zero});
        rows.push_back('{'{OP_QUERY, 0, 9, 0, 0, 0, 0, 0, 0}, 0, zero});
        rows.push_back('{'{OP_QUERY, 0, 12, 0, 0, 0, 0, 0, 1}, 1, zero});
        rows.push_back('{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0}, 1, zero});
        rows.push_back('{'{OP_QUERY, 0, 7, 0, 0, 0, 0, 0, 1}, 1, zero});

        areas  = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'h0003_8000, 32'h0100_0000};
        counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_AREA, areas[ph]);
            write_reg(CFG_COUNT, 32'(counts[ph]));
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                if (ph == 4 && n > N_RANDOM / 10) quiet = 1;
                send_item(random_item(), 0, zero);
            end
            if (ph < 4) drain();
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        wait (expected_routes.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/uhnr_pkg.sv
rtl/uhnr_div.sv
rtl/uhnr_line.sv
rtl/uhnr_sums.sv
rtl/unit_hydrograph_nutrient_router_core.sv
dv/tb.sv
